[hw/rtl/byte_pipe_ring_buffer_defines.svh]
// Assertion macros of the byte pipe ring buffer RTL.
`ifndef BYTE_PIPE_RING_BUFFER_DEFINES_SVH
`define BYTE_PIPE_RING_BUFFER_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define BPR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("byte pipe ring buffer check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define BPR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("byte pipe ring buffer check failed");

`endif

[hw/rtl/bpr_pkg.sv]
// Types, codes and sizing constants of the byte pipe ring buffer.
package bpr_pkg;

   localparam int BUF_BYTES = 4096;
   localparam int MAX_READ  = 64;
   localparam int PTR_W     = $clog2(BUF_BYTES);
   localparam int RD_W      = 7;
   localparam int CNT_W     = 12;
   localparam int SEL_W     = (PTR_W > RD_W) ? PTR_W : RD_W;

   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(BUF_BYTES - 1);
   localparam logic [PTR_W-1:0] FULL_FILL = PTR_W'(BUF_BYTES - 1);
   localparam logic [RD_W-1:0]  READ_CAP  = RD_W'(MAX_READ);
   localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

   typedef enum logic [1:0] {
      RQ_WRITE = 2'd0,
      RQ_READ  = 2'd1,
      RQ_CLOSE = 2'd2
   } req_code_type;

   typedef enum logic [2:0] {
      RK_READ_BYTE  = 3'd0,
      RK_READ_NONE  = 3'd1,
      RK_WR_DONE    = 3'd2,
      RK_WR_REFUSED = 3'd3,
      RK_CLOSE_ACK  = 3'd4
   } rsp_kind_type;

   typedef enum logic {
      ST_IDLE,
      ST_READ
   } ctrl_state_type;

   typedef struct packed {
      logic [1:0]      req_type;
      logic [7:0]      wr_byte;
      logic            wr_last;
      logic [RD_W-1:0] rd_count;
   } pipe_req_type;

   typedef struct packed {
      logic [2:0]       kind;
      logic [7:0]       rd_byte;
      logic [CNT_W-1:0] done_count;
      logic             final_result;
   } pipe_rsp_type;

   typedef struct packed {
      logic             wr_en;
      logic [PTR_W-1:0] wr_addr;
      logic [7:0]       wr_data;
      logic             rd_en;
      logic [PTR_W-1:0] rd_addr;
   } ram_cmd_type;

endpackage

[hw/rtl/bpr_ram.sv]
// Simple dual-port byte store with registered read data.
module bpr_ram #(
   parameter int DEPTH  = 4096,
   parameter int WIDTH  = 8,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/bpr_ctrl.sv]
// Pointer, fill and burst bookkeeping plus the read sequencer of the byte pipe.
`include "byte_pipe_ring_buffer_defines.svh"

module bpr_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  bpr_pkg::pipe_req_type req_item,
   output logic                 rsp_valid,
   output bpr_pkg::pipe_rsp_type rsp_item,
   output bpr_pkg::ram_cmd_type  ram_cmd,
   input  logic [7:0]           ram_rd_data
);
   import bpr_pkg::*;

   ctrl_state_type   state_ff, state_in;
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [PTR_W-1:0] fill_ff, fill_in;
   logic             shut_ff, shut_in;
   logic [CNT_W-1:0] burst_ff, burst_in;
   logic [RD_W-1:0]  remain_ff, remain_in;
   logic             rd_valid_ff, rd_valid_in;
   logic             rd_last_ff, rd_last_in;
   logic             res_valid_ff, res_valid_in;
   pipe_rsp_type     res_ff, res_in;

   logic [RD_W-1:0]  want;
   logic [RD_W-1:0]  take;
   logic [PTR_W-1:0] head_next;
   logic [PTR_W-1:0] tail_next;

   assign want      = (req_item.rd_count > READ_CAP) ? READ_CAP : req_item.rd_count;
   // The smaller of the request and the fill always fits the request width.
   assign take      = (SEL_W'(want) < SEL_W'(fill_ff)) ? want : RD_W'(fill_ff);
   assign head_next = (head_ff == LAST_SLOT) ? '0 : head_ff + PTR_W'(1);
   assign tail_next = (tail_ff == LAST_SLOT) ? '0 : tail_ff + PTR_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         fill_ff      <= '0;
         shut_ff      <= 1'b0;
         burst_ff     <= '0;
         remain_ff    <= '0;
         rd_valid_ff  <= 1'b0;
         res_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         fill_ff      <= fill_in;
         shut_ff      <= shut_in;
         burst_ff     <= burst_in;
         remain_ff    <= remain_in;
         rd_valid_ff  <= rd_valid_in;
         res_valid_ff <= res_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_last_ff <= rd_last_in;
      res_ff     <= res_in;
   end

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      fill_in      = fill_ff;
      shut_in      = shut_ff;
      burst_in     = burst_ff;
      remain_in    = remain_ff;
      rd_valid_in  = 1'b0;
      rd_last_in   = 1'b0;
      res_valid_in = 1'b0;
      res_in       = res_ff;

      ram_cmd.wr_en   = 1'b0;
      ram_cmd.wr_addr = tail_ff;
      ram_cmd.wr_data = req_item.wr_byte;
      ram_cmd.rd_en   = 1'b0;
      ram_cmd.rd_addr = head_ff;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_item.req_type)
                  RQ_WRITE: begin
                     if (!shut_ff && fill_ff < FULL_FILL) begin
                        ram_cmd.wr_en = 1'b1;
                        tail_in       = tail_next;
                        fill_in       = fill_ff + PTR_W'(1);
                        if (burst_ff != COUNT_MAX) begin
                           burst_in = burst_ff + CNT_W'(1);
                        end
                     end
                     if (req_item.wr_last) begin
                        res_valid_in        = 1'b1;
                        res_in.kind         = shut_ff ? RK_WR_REFUSED : RK_WR_DONE;
                        res_in.rd_byte      = '0;
                        res_in.done_count   = shut_ff ? '0 : burst_in;
                        res_in.final_result = 1'b1;
                        burst_in            = '0;
                     end
                  end
                  RQ_READ: begin
                     if (shut_ff || fill_ff == '0 || want == '0) begin
                        res_valid_in        = 1'b1;
                        res_in.kind         = RK_READ_NONE;
                        res_in.rd_byte      = '0;
                        res_in.done_count   = '0;
                        res_in.final_result = 1'b1;
                     end else begin
                        // The first byte is fetched in the cycle the request is taken.
                        ram_cmd.rd_en = 1'b1;
                        head_in       = head_next;
                        fill_in       = fill_ff - PTR_W'(1);
                        rd_valid_in   = 1'b1;
                        rd_last_in    = (take == RD_W'(1));
                        remain_in     = take - RD_W'(1);
                        if (take != RD_W'(1)) begin
                           state_in = ST_READ;
                        end
                     end
                  end
                  RQ_CLOSE: begin
                     shut_in             = 1'b1;
                     res_valid_in        = 1'b1;
                     res_in.kind         = RK_CLOSE_ACK;
                     res_in.rd_byte      = '0;
                     res_in.done_count   = '0;
                     res_in.final_result = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ: begin
            ram_cmd.rd_en = 1'b1;
            head_in       = head_next;
            fill_in       = fill_ff - PTR_W'(1);
            rd_valid_in   = 1'b1;
            rd_last_in    = (remain_ff == RD_W'(1));
            remain_in     = remain_ff - RD_W'(1);
            if (remain_ff == RD_W'(1)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff == ST_READ);

   // A byte fetched last cycle takes the result port; otherwise the held result.
   always_comb begin
      if (rd_valid_ff) begin
         rsp_item.kind         = RK_READ_BYTE;
         rsp_item.rd_byte      = ram_rd_data;
         rsp_item.done_count   = '0;
         rsp_item.final_result = rd_last_ff;
      end else begin
         rsp_item = res_ff;
      end
   end

   assign rsp_valid = rd_valid_ff | res_valid_ff;

   `BPR_ASSERT_NOW(a_one_result_source, clock, reset, rd_valid_ff, !res_valid_ff)
   `BPR_ASSERT_NOW(a_fill_in_range, clock, reset, 1'b1, fill_ff <= FULL_FILL)
   `BPR_ASSERT_NOW(a_read_has_work, clock, reset, state_ff == ST_READ, remain_ff != '0)
   `BPR_ASSERT_NEXT(a_read_emits, clock, reset, state_ff == ST_READ, rd_valid_ff)

endmodule

[hw/rtl/byte_pipe_ring_buffer.sv]
// Top level of the byte pipe ring buffer: control and byte store.
//
// Byte pipe on a circular buffer that keeps one slot free, so it holds at most
// 4095 bytes. Only a read that finds bytes can raise busy. The final write byte
// of a burst, a close or an empty read gives a single result on the cycle after
// the transaction; other write bytes give none. A read of more than one byte
// keeps busy high until its last byte is fetched, since the byte store has one
// read port and delivers one byte per cycle; the bytes follow one per cycle
// starting the cycle after the request, the last marked with final_result.
// Results are strobed on rsp_valid for a single cycle and cannot be held off,
// so the receiver must take every result as it appears. Reset needs no clearing
// pass: only bytes already written are ever read.
module byte_pipe_ring_buffer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  bpr_pkg::pipe_req_type req_item,
   output logic                  rsp_valid,
   output bpr_pkg::pipe_rsp_type rsp_item
);
   import bpr_pkg::*;

   ram_cmd_type ram_cmd;
   logic [7:0]  ram_rd_data;

   bpr_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_item    (req_item),
      .rsp_valid   (rsp_valid),
      .rsp_item    (rsp_item),
      .ram_cmd     (ram_cmd),
      .ram_rd_data (ram_rd_data)
   );

   bpr_ram #(
      .DEPTH  (BUF_BYTES),
      .WIDTH  (8),
      .ADDR_W (PTR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_cmd.wr_en),
      .wr_addr (ram_cmd.wr_addr),
      .wr_data (ram_cmd.wr_data),
      .rd_en   (ram_cmd.rd_en),
      .rd_addr (ram_cmd.rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule
